FILE: design/block_median_filter_top_assert.svh
// Assertion macros used by the block median filter checker.
`ifndef BLOCK_MEDIAN_FILTER_TOP_ASSERT_SVH
`define BLOCK_MEDIAN_FILTER_TOP_ASSERT_SVH

// Condition in the same cycle implies the consequence in the same cycle.
`define BMF_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("block median filter assertion failed");

// Condition in one cycle implies the consequence in the next cycle.
`define BMF_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("block median filter assertion failed");

`endif

FILE: design/bmf_pkg.sv
// Package with the constants and types of the block median filter.
package bmf_pkg;

    localparam int WINDOW     = 10;
    localparam int MEDIAN_IDX = (WINDOW - 1) / 2;
    localparam int CNT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SAMPLE_W   = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    // Per-cell control decoded from the fill count.
    typedef struct packed {
        logic load;      // an item is accepted this cycle
        logic at_fill;   // this cell is the first empty slot
        logic occupied;  // this cell holds a sample of the current block
    } bmf_cell_ctl_t;

endpackage

FILE: design/bmf_cell.sv
// One cell of the insertion chain: holds one sorted sample of the block.
module bmf_cell
(
    input  logic                   clk,
    input  bmf_pkg::bmf_cell_ctl_t ctl,
    input  bmf_pkg::sample_t       sample,
    input  bmf_pkg::sample_t       left_val,
    input  logic                   left_shift,
    output bmf_pkg::sample_t       val,
    output bmf_pkg::sample_t       val_next,
    output logic                   shift
);
    import bmf_pkg::*;

    sample_t val_reg;

    // An occupied cell whose value is above the new sample moves one place up.
    assign shift = ctl.occupied && (val_reg > sample);
    assign val   = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.load)
        begin
            if (left_shift)
            begin
                val_next = left_val;
            end
            else if (shift || ctl.at_fill)
            begin
                val_next = sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: design/block_median_filter_top.sv
// Top level of the block median filter: insertion chain plus fill count.
//
//   channel | signals            | handshake
//   --------+--------------------+-------------------------------
//   input   | start, busy, sample| taken when start && !busy
//   result  | done, median       | one-cycle strobe on done
//
// One sample is taken every cycle; busy stays low. Each sample is placed
// into the sorted cell chain in the cycle it is taken. The median of a full
// block appears on the cycle after its last sample is taken.
// Reset clears the fill count and the strobe; the cell contents stay undefined.
// The receiver cannot stall the result.
module block_median_filter_top
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  bmf_pkg::sample_t sample,
    output logic             done,
    output bmf_pkg::sample_t median
);
    import bmf_pkg::*;

    logic           accept;
    logic           last;
    cnt_t           count_reg;
    cnt_t           count_next;
    logic           done_reg;
    sample_t        median_reg;
    bmf_cell_ctl_t  ctl      [WINDOW];
    sample_t        cell_val [WINDOW];
    sample_t        cell_nxt [WINDOW];
    logic           cell_sh  [WINDOW];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign last   = (count_reg == cnt_t'(WINDOW - 1));

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW; gi++)
        begin : g_cell
            assign ctl[gi].load     = accept;
            assign ctl[gi].at_fill  = (count_reg == cnt_t'(gi));
            assign ctl[gi].occupied = (count_reg > cnt_t'(gi));

            if (gi == 0)
            begin : g_first
                bmf_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl[gi]),
                    .sample     (sample),
                    .left_val   (sample),
                    .left_shift (1'b0),
                    .val        (cell_val[gi]),
                    .val_next   (cell_nxt[gi]),
                    .shift      (cell_sh[gi])
                );
            end
            else
            begin : g_rest
                bmf_cell u_cell
                (
                    .clk        (clk),
                    .ctl        (ctl[gi]),
                    .sample     (sample),
                    .left_val   (cell_val[gi-1]),
                    .left_shift (cell_sh[gi-1]),
                    .val        (cell_val[gi]),
                    .val_next   (cell_nxt[gi]),
                    .shift      (cell_sh[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = last ? '0 : count_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept && last;
        end
    end

    // The median cell's next value already includes the last sample.
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            median_reg <= cell_nxt[MEDIAN_IDX];
        end
    end

    assign done   = done_reg;
    assign median = median_reg;

endmodule

FILE: design/bmf_checker.sv
// Port-level checker for the block median filter, bound to the top level.
`include "block_median_filter_top_assert.svh"

module bmf_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input bmf_pkg::sample_t sample,
    input logic             done,
    input bmf_pkg::sample_t median
);
    import bmf_pkg::*;

    cnt_t acc_cnt_reg;
    cnt_t acc_cnt_next;
    logic accepted;
    logic block_end;

    assign accepted  = start && !busy;
    assign block_end = accepted && (acc_cnt_reg == cnt_t'(WINDOW - 1));

    always_comb
    begin
        acc_cnt_next = acc_cnt_reg;
        if (accepted)
        begin
            acc_cnt_next = block_end ? '0 : acc_cnt_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_cnt_reg <= '0;
        end
        else
        begin
            acc_cnt_reg <= acc_cnt_next;
        end
    end

    // A result follows exactly the last item of each block.
    `BMF_ASSERT_NEXT(a_done_after_block, block_end, done)
    `BMF_ASSERT_NEXT(a_no_done_mid_block, !block_end, !done)
    // Blocks hold at least three items, so results never come back to back.
    `BMF_ASSERT_NEXT(a_done_single, done, !done)
    // When the last sample of a block is known, the median must be known.
    `BMF_ASSERT_SAME(a_median_known, done && !$isunknown($past(sample)), !$isunknown(median))

endmodule

bind block_median_filter_top bmf_checker u_bmf_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .sample (sample),
    .done   (done),
    .median (median)
);
